// File: design/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg
// shared constants for the ray / sphere intersection pipeline
// ----------------------------------------------------------------------------
package rsi_pkg;

	// default number formats
	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;

	// reset value of the near threshold
	localparam int NEAR_RESET = 66;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X       = 3'd0,
		REG_CENTER_Y       = 3'd1,
		REG_CENTER_Z       = 3'd2,
		REG_RADIUS_SQUARED = 3'd3,
		REG_NEAR_THRESHOLD = 3'd4
	} cfg_reg_t;

endpackage

// File: design/ray_sphere_intersect_top.sv
// ----------------------------------------------------------------------------
// ray_sphere_intersect_top
// fully pipelined ray against sphere test, one ray per cycle while the output is not held
// the square root takes one result bit per stage and sets most of the pipe depth
// throughput: one ray request per cycle; the whole pipe stalls only while a
// result is held on the output and not taken
// reset: arst_n clears all valid bits and loads the default sphere
// (center 0, radius 1.0, near threshold 66)
// ----------------------------------------------------------------------------
module ray_sphere_intersect_top
	import rsi_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [CFG_IDX_W-1:0]              cfg_index,
	input  logic [2*COORD_WIDTH-3:0]          cfg_data,
	// ray requests
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, zero fill
	input  logic [((3*COORD_WIDTH+3*(FRAC_BITS+2)+7)/8)*8-1:0] s_tdata,
	// results
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// distance, zero fill
	output logic [((COORD_WIDTH-1+7)/8)*8-1:0] m_tdata,
	// hit
	output logic                              m_tuser
);

	// widths
	localparam int W     = COORD_WIDTH;
	localparam int F     = FRAC_BITS;
	localparam int DW    = F + 2;            // direction
	localparam int RSQW  = 2*W - 2;          // squared radius
	localparam int DISTW = W - 1;            // distance out
	localparam int DDW   = W + 1;            // origin minus center
	localparam int PHW   = DW + DDW;         // dir * d
	localparam int HBW   = W + F + 5;        // half_b
	localparam int PDW   = 2*DDW;            // d * d
	localparam int DDSW  = 2*W + 4;          // d . d
	localparam int CW    = 2*W + 5;          // c
	localparam int L     = (HBW + 1) / 2;    // low half of half_b for squaring
	localparam int HIW   = HBW - L;
	localparam int SQRW  = 2*HBW;            // half_b squared, c scaled
	localparam int DSW   = 2*HBW + 1;        // discriminant
	localparam int RADW  = 2*HBW;            // radicand
	localparam int SQW   = HBW;              // square root
	localparam int TRW   = RADW + 1;
	localparam int NHW   = HBW + 1;
	localparam int TW    = HBW + 2;          // roots
	localparam int TDW   = ((DISTW + 7) / 8) * 8;

	localparam logic [DISTW-1:0] DMAX = {DISTW{1'b1}};
	localparam logic [RSQW-1:0]  RSQ_RESET = RSQW'(1) << (2*F);

	// ------------------------------------------------------------------
	// configuration registers, always ready
	// ------------------------------------------------------------------
	logic signed [W-1:0] center_x_q, center_y_q, center_z_q;
	logic [RSQW-1:0]     rsq_q;
	logic [F-1:0]        near_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			center_z_q <= '0;
			rsq_q      <= RSQ_RESET;
			near_q     <= F'(NEAR_RESET);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CENTER_X:       center_x_q <= cfg_data[W-1:0];
				REG_CENTER_Y:       center_y_q <= cfg_data[W-1:0];
				REG_CENTER_Z:       center_z_q <= cfg_data[W-1:0];
				REG_RADIUS_SQUARED: rsq_q      <= cfg_data[RSQW-1:0];
				REG_NEAR_THRESHOLD: near_q     <= cfg_data[F-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// global pipeline advance: every stage moves unless the output is held
	// ------------------------------------------------------------------
	logic ce;
	assign ce       = !m_tvalid || m_tready;
	assign s_tready = ce;

	// input fields
	logic signed [W-1:0]  in_o [3];
	logic signed [DW-1:0] in_d [3];
	assign in_o[0] = s_tdata[W-1:0];
	assign in_o[1] = s_tdata[2*W-1:W];
	assign in_o[2] = s_tdata[3*W-1:2*W];
	assign in_d[0] = s_tdata[3*W+DW-1:3*W];
	assign in_d[1] = s_tdata[3*W+2*DW-1:3*W+DW];
	assign in_d[2] = s_tdata[3*W+3*DW-1:3*W+2*DW];

	logic signed [W-1:0] ctr [3];
	assign ctr[0] = center_x_q;
	assign ctr[1] = center_y_q;
	assign ctr[2] = center_z_q;

	// ------------------------------------------------------------------
	// s1: d = origin - center
	// ------------------------------------------------------------------
	logic                  vld_s1;
	logic signed [DDW-1:0] d_s1   [3];
	logic signed [DW-1:0]  dir_s1 [3];

	// s2: per axis products
	logic                  vld_s2;
	logic signed [PHW-1:0] phb_s2 [3];
	logic signed [PDW-1:0] pdd_s2 [3];

	// s3: dot products
	logic                   vld_s3;
	logic signed [HBW-1:0]  hb_s3;
	logic signed [DDSW-1:0] dd_s3;

	// s4: c and partial squares of half_b
	logic                       vld_s4;
	logic signed [HBW-1:0]      hb_s4;
	logic signed [CW-1:0]       c_s4;
	logic signed [2*HIW-1:0]    hh_s4;
	logic signed [HIW+L:0]      hl_s4;
	logic [2*L-1:0]             ll_s4;

	// s5: half_b squared, c scaled
	logic                   vld_s5;
	logic signed [HBW-1:0]  hb_s5;
	logic signed [SQRW-1:0] sq_s5;
	logic signed [SQRW-1:0] cs_s5;

	// s6 feeds the square root at index 0
	logic                  sr_vld_s  [SQW+1];
	logic                  sr_miss_s [SQW+1];
	logic signed [NHW-1:0] sr_nhb_s  [SQW+1];
	logic [RADW-1:0]       sr_rem_s  [SQW+1];
	logic [SQW-1:0]        sr_res_s  [SQW+1];

	logic signed [HIW-1:0] hb_hi;
	logic [L-1:0]          hb_lo;
	logic signed [DSW-1:0] disc;
	assign hb_hi = hb_s3[HBW-1:L];
	assign hb_lo = hb_s3[L-1:0];
	assign disc  = DSW'(sq_s5) - DSW'(cs_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1       <= 1'b0;
			vld_s2       <= 1'b0;
			vld_s3       <= 1'b0;
			vld_s4       <= 1'b0;
			vld_s5       <= 1'b0;
			sr_vld_s[0]  <= 1'b0;
		end else if (ce) begin
			vld_s1       <= s_tvalid;
			vld_s2       <= vld_s1;
			vld_s3       <= vld_s2;
			vld_s4       <= vld_s3;
			vld_s5       <= vld_s4;
			sr_vld_s[0]  <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i]   <= DDW'(in_o[i]) - DDW'(ctr[i]);
				dir_s1[i] <= in_d[i];
				phb_s2[i] <= PHW'(dir_s1[i]) * PHW'(d_s1[i]);
				pdd_s2[i] <= PDW'(d_s1[i]) * PDW'(d_s1[i]);
			end
			hb_s3 <= HBW'(phb_s2[0]) + HBW'(phb_s2[1]) + HBW'(phb_s2[2]);
			dd_s3 <= DDSW'(pdd_s2[0]) + DDSW'(pdd_s2[1]) + DDSW'(pdd_s2[2]);
			// hb = hi * 2^L + lo
			hb_s4 <= hb_s3;
			c_s4  <= CW'(dd_s3) - CW'(signed'({1'b0, rsq_q}));
			hh_s4 <= (2*HIW)'(hb_hi) * (2*HIW)'(hb_hi);
			hl_s4 <= (HIW+L+1)'(hb_hi) * (HIW+L+1)'(signed'({1'b0, hb_lo}));
			ll_s4 <= (2*L)'(hb_lo) * (2*L)'(hb_lo);
			hb_s5 <= hb_s4;
			sq_s5 <= (SQRW'(hh_s4) <<< (2*L)) + (SQRW'(hl_s4) <<< (L+1))
				+ SQRW'(signed'({1'b0, ll_s4}));
			cs_s5 <= SQRW'(c_s4) <<< (2*F);
			// s6: discriminant, sign gives the miss
			sr_miss_s[0] <= disc[DSW-1];
			sr_rem_s[0]  <= disc[RADW-1:0];
			sr_res_s[0]  <= '0;
			sr_nhb_s[0]  <= -NHW'(hb_s5);
		end
	end

	// ------------------------------------------------------------------
	// square root, one result bit per stage (restoring, remainder form)
	// ------------------------------------------------------------------
	for (genvar i = 0; i < SQW; i++) begin : g_sqrt
		localparam int K = SQW - 1 - i;
		logic [TRW-1:0] trial;
		logic           take;
		assign trial = (TRW'(sr_res_s[i]) << (K+1)) | (TRW'(1) << (2*K));
		assign take  = TRW'(sr_rem_s[i]) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sr_vld_s[i+1] <= 1'b0;
			end else if (ce) begin
				sr_vld_s[i+1] <= sr_vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				sr_miss_s[i+1] <= sr_miss_s[i];
				sr_nhb_s[i+1]  <= sr_nhb_s[i];
				if (take) begin
					sr_rem_s[i+1] <= RADW'(TRW'(sr_rem_s[i]) - trial);
					sr_res_s[i+1] <= sr_res_s[i] | (SQW'(1) << K);
				end else begin
					sr_rem_s[i+1] <= sr_rem_s[i];
					sr_res_s[i+1] <= sr_res_s[i];
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// f1: both roots; f2: pick against threshold, scale, saturate
	// ------------------------------------------------------------------
	logic                 vld_f1, miss_f1;
	logic signed [TW-1:0] tn_f1, tf_f1;
	logic signed [TW-1:0] thr;
	logic signed [TW-1:0] t_sel;
	logic                 near_ok, far_ok;
	logic signed [TW-1:0] q;
	logic                 hit_d;
	logic [DISTW-1:0]     dist_d;

	assign thr     = TW'(signed'({1'b0, near_q})) <<< F;
	assign near_ok = thr < tn_f1;
	assign far_ok  = thr < tf_f1;
	assign t_sel   = near_ok ? tn_f1 : tf_f1;
	assign q       = t_sel >>> F;
	assign hit_d   = !miss_f1 && (near_ok || far_ok);
	assign dist_d  = (!hit_d || q > TW'(signed'({1'b0, DMAX}))) ? DMAX : q[DISTW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_f1   <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (ce) begin
			vld_f1   <= sr_vld_s[SQW];
			m_tvalid <= vld_f1;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			miss_f1 <= sr_miss_s[SQW];
			tn_f1   <= TW'(sr_nhb_s[SQW]) - TW'(signed'({1'b0, sr_res_s[SQW]}));
			tf_f1   <= TW'(sr_nhb_s[SQW]) + TW'(signed'({1'b0, sr_res_s[SQW]}));
			m_tuser <= hit_d;
			m_tdata <= TDW'(dist_d);
		end
	end

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	a_miss_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[DISTW-1:0] == DMAX)
		else $error("miss without maximum distance");

	a_hit_thr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[DISTW-1:0] >= DISTW'(near_q))
		else $error("hit below near threshold");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_s1)
		else $error("accepted ray not in first stage");

endmodule

// File: bench/rsi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_checker
// watches the ray, result and configuration channels of the intersection
// block, predicts every result from its own copy of the sphere registers
// and compares the results in order
// ----------------------------------------------------------------------------
module rsi_checker
	import rsi_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [61:0]  cfg_data,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [151:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [31:0]  m_tdata,
	input  logic         m_tuser,
	output int           errors,
	output int           pending,
	output int           results,
	output int           hits
);

	localparam logic [30:0] DIST_MAX = '1;

	typedef struct packed {
		logic        hit;
		logic [30:0] distance;
	} hit_result_t;

	logic signed [31:0] sph_cx, sph_cy, sph_cz;
	logic [61:0]        sph_rsq;
	logic [15:0]        sph_near;

	hit_result_t expected_hits[$];

	assign pending = expected_hits.size();

	// floor square root of a non-negative 128-bit value
	function automatic logic [127:0] floor_sqrt(input logic [127:0] v);
		logic [127:0] root, probe, trial;
		root  = '0;
		probe = 128'd1 << 126;
		for (int i = 0; i < 64; i++) begin
			trial = root + probe;
			if (v >= trial) begin
				v    = v - trial;
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root;
	endfunction

	function automatic hit_result_t trace_ray(input logic [151:0] ray);
		logic signed [31:0]  org[3];
		logic signed [17:0]  dir[3];
		logic signed [31:0]  ctr[3];
		logic signed [127:0] d, half_b, dsq, c_term, disc, root_s, neg_hb, thr, t, q;
		hit_result_t r;
		org[0] = ray[31:0];
		org[1] = ray[63:32];
		org[2] = ray[95:64];
		dir[0] = ray[113:96];
		dir[1] = ray[131:114];
		dir[2] = ray[149:132];
		ctr[0] = sph_cx;
		ctr[1] = sph_cy;
		ctr[2] = sph_cz;
		half_b = '0;
		dsq    = '0;
		for (int i = 0; i < 3; i++) begin
			d      = 128'(org[i]) - 128'(ctr[i]);
			half_b = half_b + 128'(dir[i]) * d;
			dsq    = dsq + d * d;
		end
		c_term = dsq - $signed({66'd0, sph_rsq});
		disc   = half_b * half_b - (c_term <<< 32);
		r.hit      = 1'b0;
		r.distance = DIST_MAX;
		if (disc < 0)
			return r;
		root_s = floor_sqrt(disc);
		neg_hb = -half_b;
		thr    = $signed({96'd0, sph_near, 16'd0});
		t      = neg_hb - root_s;
		if (!(t > thr)) begin
			// nearer root too close, fall back to the farther one
			t = neg_hb + root_s;
			if (!(t > thr))
				return r;
		end
		q          = t >>> 16;
		r.hit      = 1'b1;
		r.distance = (q > 128'(DIST_MAX)) ? DIST_MAX : q[30:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		hit_result_t want;
		if (!arst_n) begin
			sph_cx   <= '0;
			sph_cy   <= '0;
			sph_cz   <= '0;
			sph_rsq  <= 62'd1 << 32;
			sph_near <= 16'(NEAR_RESET);
			errors   <= 0;
			results  <= 0;
			hits     <= 0;
			expected_hits.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_CENTER_X:       sph_cx   <= cfg_data[31:0];
					REG_CENTER_Y:       sph_cy   <= cfg_data[31:0];
					REG_CENTER_Z:       sph_cz   <= cfg_data[31:0];
					REG_RADIUS_SQUARED: sph_rsq  <= cfg_data;
					REG_NEAR_THRESHOLD: sph_near <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				results <= results + 1;
				if (m_tuser)
					hits <= hits + 1;
				if (expected_hits.size() == 0) begin
					$display("%t: unexpected result hit=%0d distance=%h", $realtime,
						m_tuser, m_tdata);
					errors <= errors + 1;
				end else begin
					want = expected_hits.pop_front();
					if (m_tuser !== want.hit || m_tdata !== {1'b0, want.distance}) begin
						$display("%t: mismatch expected hit=%0d distance=%h, got hit=%0d distance=%h",
							$realtime, want.hit, want.distance, m_tuser, m_tdata);
						errors <= errors + 1;
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_hits.push_back(trace_ray(s_tdata));
		end
	end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// ray / sphere intersection: directed rays on the default sphere and at the
// numeric extremes, then phases of random rays against random spheres, with
// random gaps and stalls on both streams; checking lives in rsi_checker
// ----------------------------------------------------------------------------
module testbench;
	import rsi_pkg::*;

	localparam int LATENCY   = 61;
	localparam int MAX_CYCLE = 600000;
	localparam logic signed [17:0] ONE = 18'sd65536;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [2:0]   cfg_index = '0;
	logic [61:0]  cfg_data = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [151:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [31:0]  m_tdata;
	logic         m_tuser;

	int errors, pending, results, hits;
	int cycle_count = 0;
	int rays_sent = 0;
	// gap and stall switches, cleared for the quiet stretches
	bit send_gaps = 1'b1;
	bit recv_stalls = 1'b1;
	int stall_left = 0;

	ray_sphere_intersect_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	rsi_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.errors(errors), .pending(pending), .results(results), .hits(hits)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > MAX_CYCLE) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// short gaps mostly, an occasional long one
	function automatic int pick_gap();
		if ($urandom_range(9) < 8)
			return $urandom_range(3);
		return $urandom_range(50, 20);
	endfunction

	// result side back-pressure
	always @(negedge clk) begin
		if (!recv_stalls || stall_left == 0) begin
			m_tready <= 1'b1;
			if (recv_stalls && $urandom_range(7) == 0)
				stall_left = pick_gap() + 1;
		end else begin
			m_tready <= 1'b0;
			stall_left = stall_left - 1;
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [61:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// one ray request; valid stays high into the next request when no gap follows
	task automatic send_ray(input logic signed [31:0] ox, oy, oz,
			input logic signed [17:0] dx, dy, dz);
		int gap;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, dz, dy, dx, oz, oy, ox};
		do @(posedge clk); while (!s_tready);
		rays_sent++;
		gap = send_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// wait for every result, then let the pipe drain before touching registers
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic set_sphere(input logic [31:0] cx, cy, cz, input logic [61:0] rsq,
			input logic [15:0] near);
		write_reg(REG_CENTER_X, 62'(cx));
		write_reg(REG_CENTER_Y, 62'(cy));
		write_reg(REG_CENTER_Z, 62'(cz));
		write_reg(REG_RADIUS_SQUARED, rsq);
		write_reg(REG_NEAR_THRESHOLD, 62'(near));
	endtask

	// rays mostly aimed at the sphere along an axis, some skewed, some noise
	task automatic random_rays(input int count, input logic signed [31:0] cx, cy, cz,
			input longint radius);
		longint off[3];
		logic signed [17:0] dv[3];
		int axis, sgn;
		for (int n = 0; n < count; n++) begin
			int kind = $urandom_range(9);
			if (kind < 5) begin
				axis = $urandom_range(2);
				sgn  = $urandom_range(1) ? 1 : -1;
				for (int k = 0; k < 3; k++) begin
					off[k] = longint'($urandom_range(2400)) * radius / 1000 - radius * 6 / 5;
					dv[k]  = '0;
				end
				off[axis] = -sgn * (longint'($urandom_range(4000)) * radius / 1000);
				dv[axis]  = sgn > 0 ? ONE : -ONE;
				send_ray(32'(cx + off[0]), 32'(cy + off[1]), 32'(cz + off[2]),
					dv[0], dv[1], dv[2]);
			end else if (kind < 8) begin
				for (int k = 0; k < 3; k++)
					off[k] = longint'($urandom_range(8000)) * radius / 1000 - radius * 4;
				send_ray(32'(cx + off[0]), 32'(cy + off[1]), 32'(cz + off[2]),
					18'($urandom_range(131072) - 65536),
					18'($urandom_range(131072) - 65536),
					18'($urandom_range(131072) - 65536));
			end else begin
				send_ray($urandom, $urandom, $urandom,
					18'($urandom), 18'($urandom), 18'($urandom));
			end
		end
	endtask

	initial begin
		logic [31:0] cx, cy, cz;
		longint radius;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// default sphere: unit radius at the origin, threshold 66
		send_ray(-32'sd327680, 0, 0, ONE, 0, 0);          // plain hit from outside
		send_ray(0, 0, 32'sd327680, 0, 0, -ONE);          // hit along -z
		send_ray(0, 0, 0, 0, ONE, 0);                     // from inside, farther root
		send_ray(32'sd65536, -32'sd327680, 0, 0, ONE, 0); // tangent, zero discriminant
		send_ray(32'sd200000, -32'sd327680, 0, 0, ONE, 0);// clean miss
		send_ray(-32'sd65536, 0, 0, ONE, 0, 0);           // on the surface, near root rejected
		send_ray(32'sd327680, 0, 0, ONE, 0, 0);           // sphere behind the ray
		send_ray(32'h7fffffff, 32'h80000000, 32'h7fffffff, -ONE, ONE, -ONE);
		send_ray(32'h80000000, 32'h80000000, 32'h80000000, ONE, ONE, ONE);
		send_ray(-32'sd327680, 0, 0, 18'h1ffff, 18'h20000, 18'h3ffff); // raw direction extremes
		send_ray(0, 0, 0, 0, 0, 0);                        // zero direction
		settle();

		// far away small sphere, hit distance saturates
		set_sphere(32'h7fffffff, 0, 0, 62'd1 << 32, 16'h0000);
		send_ray(32'h80000000, 0, 0, ONE, 0, 0);
		send_ray(32'h80000000, 32'sd32768, 0, ONE, 0, 0);
		send_ray(32'h7fff0000, 0, 0, ONE, 0, 0);
		settle();

		// huge radius, top threshold, and the empty sphere
		set_sphere(32'h80000000, 32'h80000000, 32'h80000000, '1, 16'hffff);
		send_ray(0, 0, 0, -ONE, 0, 0);
		send_ray(32'h80000000, 32'h80000000, 32'h80000000, 0, 0, ONE);
		send_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, -ONE, -ONE, -ONE);
		settle();
		set_sphere(0, 0, 0, '0, 16'd0);
		send_ray(-32'sd65536, 0, 0, ONE, 0, 0);
		send_ray(-32'sd65536, 1, 0, ONE, 0, 0);
		settle();

		// random spheres; phase 0 runs with no gaps or stalls
		for (int ph = 0; ph < 8; ph++) begin
			send_gaps   = (ph != 0);
			recv_stalls = (ph != 0) && (ph != 5);
			radius = (ph == 3) ? longint'($urandom_range(16)) + 1 :
				(ph == 6) ? longint'($urandom_range(1 << 24, 1 << 22)) :
				longint'($urandom_range(1 << 20, 1024));
			cx = (ph == 7) ? 32'h7fff0000 : 32'($urandom_range(1 << 26)) - (1 << 25);
			cy = (ph == 7) ? 32'h80010000 : 32'($urandom_range(1 << 26)) - (1 << 25);
			cz = 32'($urandom_range(1 << 26)) - (1 << 25);
			set_sphere(cx, cy, cz, 62'(radius * radius),
				(ph == 2) ? 16'hffff : (ph == 4) ? 16'd0 : 16'($urandom));
			random_rays(160, cx, cy, cz, radius);
			settle();
		end

		$display("rays sent: %0d, results checked: %0d, of which hits: %0d",
			rays_sent, results, hits);
		$display("covered default, saturating, empty and random spheres under stalls");
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
